/* sv/expression_line_tokenizer_core_assert.svh */
// Assertion macros shared by the tokenizer modules.
`ifndef EXPRESSION_LINE_TOKENIZER_CORE_ASSERT_SVH
`define EXPRESSION_LINE_TOKENIZER_CORE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define ELT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition is followed by a property on the next edge.
`define ELT_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

/* sv/elt_pkg.sv */
// Shared types, constants and byte classification for the line tokenizer.
package elt_pkg;

  localparam int MAX_LINE      = 4096;
  localparam int MAX_TOKEN_LEN = 255;

  localparam int KIND_W = 4;
  localparam int POS_W  = 12;
  localparam int LEN_W  = 8;

  localparam int POS_CAP_I = ((MAX_LINE - 1) < 4095) ? (MAX_LINE - 1) : 4095;
  localparam int LEN_CAP_I = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;
  localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_CAP_I);
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_I);

  localparam logic [LEN_W-1:0] LEN_ZERO = '0;
  localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_TWO  = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_THREE = LEN_W'(3);
  localparam logic [LEN_W-1:0] LEN_FOUR = LEN_W'(4);

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QCNT_W-1:0] QUEUE_FULL = QCNT_W'(QUEUE_DEPTH);

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LC_I   = 8'h69;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_C   = 8'h63;
  localparam logic [7:0] CH_LC_O   = 8'h6F;
  localparam logic [7:0] CH_LC_U   = 8'h75;

  typedef enum logic [KIND_W-1:0] {
    KIND_INT      = 4'd0,
    KIND_KW_INT   = 4'd1,
    KIND_KW_COUT  = 4'd2,
    KIND_IDENT    = 4'd3,
    KIND_EQ       = 4'd4,
    KIND_PLUS     = 4'd5,
    KIND_SEMI     = 4'd6,
    KIND_COMMA    = 4'd7,
    KIND_LPAREN   = 4'd8,
    KIND_RPAREN   = 4'd9,
    KIND_SHL      = 4'd10,
    KIND_EOL      = 4'd11,
    KIND_ERR_LT   = 4'd12,
    KIND_ERR_MINUS = 4'd13,
    KIND_ERR_ALPHA = 4'd14,
    KIND_ERR_CHAR = 4'd15
  } token_kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_IDENT = 3'd1,
    MODE_INT   = 3'd2,
    MODE_LT    = 3'd3,
    MODE_MINUS = 3'd4,
    MODE_SKIP  = 3'd5
  } scan_mode_t;

  typedef enum logic [2:0] {
    CLS_WS,
    CLS_PUNCT,
    CLS_LT,
    CLS_MINUS,
    CLS_DIGIT,
    CLS_WORD,
    CLS_OTHER
  } char_class_t;

  typedef struct packed {
    token_kind_t       kind;
    logic [POS_W-1:0]  start;
    logic [LEN_W-1:0]  length;
  } tok_t;

  // All descriptors caused by one byte, oldest in slot 0.
  typedef struct packed {
    logic [1:0]      count;
    tok_t [2:0]      toks;
  } bundle_t;

  function automatic char_class_t classify(logic [7:0] c);
    char_class_t cls;
    if (c == CH_SPACE || c == CH_TAB || c == CH_NL) cls = CLS_WS;
    else if (c == CH_EQ || c == CH_PLUS || c == CH_SEMI || c == CH_COMMA ||
             c == CH_LPAREN || c == CH_RPAREN) cls = CLS_PUNCT;
    else if (c == CH_LT) cls = CLS_LT;
    else if (c == CH_MINUS) cls = CLS_MINUS;
    else if (c >= 8'h30 && c <= 8'h39) cls = CLS_DIGIT;
    else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             c == CH_UNDER) cls = CLS_WORD;
    else cls = CLS_OTHER;
    return cls;
  endfunction

  function automatic token_kind_t punct_kind(logic [7:0] c);
    token_kind_t k;
    case (c)
      CH_EQ:     k = KIND_EQ;
      CH_PLUS:   k = KIND_PLUS;
      CH_SEMI:   k = KIND_SEMI;
      CH_COMMA:  k = KIND_COMMA;
      CH_LPAREN: k = KIND_LPAREN;
      default:   k = KIND_RPAREN;
    endcase
    return k;
  endfunction

  // Narrow the keyword candidates with the byte at position p of the token.
  function automatic logic [1:0] kw_step(logic [1:0] kw, logic [LEN_W-1:0] p,
                                         logic [7:0] c);
    logic [1:0] m;
    m = kw;
    if (!((p == LEN_ZERO && c == CH_LC_I) || (p == LEN_ONE && c == CH_LC_N) ||
          (p == LEN_TWO && c == CH_LC_T))) m[0] = 1'b0;
    if (!((p == LEN_ZERO && c == CH_LC_C) || (p == LEN_ONE && c == CH_LC_O) ||
          (p == LEN_TWO && c == CH_LC_U) || (p == LEN_THREE && c == CH_LC_T)))
      m[1] = 1'b0;
    return m;
  endfunction

  function automatic token_kind_t flush_kind(scan_mode_t mode, logic [1:0] kw,
                                             logic [LEN_W-1:0] len);
    token_kind_t k;
    if (mode == MODE_INT) k = KIND_INT;
    else if (kw[0] && len == LEN_THREE) k = KIND_KW_INT;
    else if (kw[1] && len == LEN_FOUR) k = KIND_KW_COUT;
    else k = KIND_IDENT;
    return k;
  endfunction

  function automatic logic [LEN_W-1:0] len_inc(logic [LEN_W-1:0] len);
    logic [LEN_W:0] s;
    s = {1'b0, len} + {{LEN_W{1'b0}}, 1'b1};
    return (s > {1'b0, LEN_CAP}) ? LEN_CAP : s[LEN_W-1:0];
  endfunction

endpackage

/* sv/elt_in_if.sv */
// Byte channel: one source byte and its last-of-line flag.
interface elt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       line_end;

  modport source (output valid, char_in, line_end, input ready);
  modport sink (input valid, char_in, line_end, output ready);
endinterface

/* sv/elt_out_if.sv */
// Token channel: one token descriptor per item.
interface elt_out_if;
  logic                      valid;
  logic                      ready;
  logic [elt_pkg::KIND_W-1:0] token_kind;
  logic [elt_pkg::POS_W-1:0]  token_start;
  logic [elt_pkg::LEN_W-1:0]  token_length;
  logic                      run_end;

  modport source (output valid, token_kind, token_start, token_length, run_end,
                  input ready);
  modport sink (input valid, token_kind, token_start, token_length, run_end,
                output ready);
endinterface

/* sv/elt_front.sv */
// Front part: scan state and per-byte classification into descriptor bundles.
module elt_front (
  input  logic             clk,
  input  logic             rst,
  elt_in_if.sink           byte_ch,
  output logic             push_valid,
  input  logic             push_ready,
  output elt_pkg::bundle_t push_data
);
  import elt_pkg::*;

  scan_mode_t        scan_mode, scan_mode_next;
  logic [POS_W-1:0]  start_pos, start_pos_next;
  logic [LEN_W-1:0]  tok_len, tok_len_next;
  logic [1:0]        kw_match, kw_match_next;
  logic [POS_W-1:0]  byte_pos, byte_pos_next;

  scan_mode_t        mid_mode;
  logic [POS_W-1:0]  mid_start;
  logic [LEN_W-1:0]  mid_len;
  logic [1:0]        mid_kw;

  logic [7:0]        c;
  char_class_t       cls;
  logic [POS_W-1:0]  pos_sat;
  logic [POS_W:0]    pos_inc;
  logic              fire;
  bundle_t           bundle;

  assign c       = byte_ch.char_in;
  assign cls     = classify(c);
  assign pos_inc = {1'b0, byte_pos} + {{POS_W{1'b0}}, 1'b1};
  assign pos_sat = (pos_inc > {1'b0, POS_CAP}) ? POS_CAP : pos_inc[POS_W-1:0];

  assign byte_ch.ready = push_ready;
  assign fire          = byte_ch.valid && push_ready;
  assign push_valid    = byte_ch.valid && (bundle.count != 2'd0);
  assign push_data     = bundle;

  // Next state: byte effect first, then the line-end reset.
  always_comb begin
    mid_mode  = scan_mode;
    mid_start = start_pos;
    mid_len   = tok_len;
    mid_kw    = kw_match;
    unique case (scan_mode)
      MODE_SKIP: ;
      MODE_LT: mid_mode = (cls == CLS_LT) ? MODE_IDLE : MODE_SKIP;
      MODE_MINUS: begin
        if (cls == CLS_DIGIT) begin
          mid_mode = MODE_INT;
          mid_len  = LEN_TWO;
        end else begin
          mid_mode = MODE_SKIP;
        end
      end
      default: begin
        unique case (cls)
          CLS_WS:    mid_mode = MODE_IDLE;
          CLS_PUNCT: mid_mode = MODE_IDLE;
          CLS_LT: begin
            mid_mode  = MODE_LT;
            mid_start = byte_pos;
          end
          CLS_MINUS: begin
            mid_mode  = MODE_MINUS;
            mid_start = byte_pos;
          end
          CLS_DIGIT: begin
            if (scan_mode == MODE_IDLE) begin
              mid_mode  = MODE_INT;
              mid_start = byte_pos;
              mid_len   = LEN_ONE;
              mid_kw    = kw_step(2'b11, LEN_ZERO, c);
            end else begin
              mid_kw  = kw_step(kw_match, tok_len, c);
              mid_len = len_inc(tok_len);
            end
          end
          CLS_WORD: begin
            if (scan_mode == MODE_IDLE) begin
              mid_mode  = MODE_IDENT;
              mid_start = byte_pos;
              mid_len   = LEN_ONE;
              mid_kw    = kw_step(2'b11, LEN_ZERO, c);
            end else if (scan_mode == MODE_IDENT) begin
              mid_kw  = kw_step(kw_match, tok_len, c);
              mid_len = len_inc(tok_len);
            end else begin
              mid_mode = MODE_SKIP;
            end
          end
          default: mid_mode = MODE_SKIP;
        endcase
      end
    endcase

    if (byte_ch.line_end) begin
      scan_mode_next = MODE_IDLE;
      start_pos_next = '0;
      tok_len_next   = LEN_ZERO;
      kw_match_next  = 2'b11;
      byte_pos_next  = '0;
    end else begin
      scan_mode_next = mid_mode;
      start_pos_next = mid_start;
      tok_len_next   = mid_len;
      kw_match_next  = mid_kw;
      byte_pos_next  = pos_sat;
    end
  end

  // Outputs: collect the descriptors this byte causes.
  always_comb begin
    bundle = '0;
    unique case (scan_mode)
      MODE_SKIP: ;
      MODE_LT: begin
        if (cls == CLS_LT) bundle.toks[0] = '{KIND_SHL, start_pos, LEN_TWO};
        else bundle.toks[0] = '{KIND_ERR_LT, start_pos, LEN_ONE};
        bundle.count = 2'd1;
      end
      MODE_MINUS: begin
        if (cls != CLS_DIGIT) begin
          bundle.toks[0] = '{KIND_ERR_MINUS, start_pos, LEN_ONE};
          bundle.count   = 2'd1;
        end
      end
      default: begin
        // Flush a pending word on whitespace or an operator.
        if ((cls == CLS_WS || cls == CLS_PUNCT || cls == CLS_LT || cls == CLS_MINUS) &&
            scan_mode != MODE_IDLE) begin
          bundle.toks[0] = '{flush_kind(scan_mode, kw_match, tok_len), start_pos, tok_len};
          bundle.count   = 2'd1;
        end
        if (cls == CLS_PUNCT) begin
          bundle.toks[bundle.count] = '{punct_kind(c), byte_pos, LEN_ONE};
          bundle.count = bundle.count + 2'd1;
        end else if (cls == CLS_WORD && scan_mode == MODE_INT) begin
          bundle.toks[0] = '{KIND_ERR_ALPHA, start_pos, len_inc(tok_len)};
          bundle.count   = 2'd1;
        end else if (cls == CLS_OTHER) begin
          bundle.toks[0] = '{KIND_ERR_CHAR, byte_pos, LEN_ONE};
          bundle.count   = 2'd1;
        end
      end
    endcase

    if (byte_ch.line_end) begin
      if (mid_mode == MODE_IDENT || mid_mode == MODE_INT) begin
        bundle.toks[bundle.count] = '{flush_kind(mid_mode, mid_kw, mid_len), mid_start,
                                      mid_len};
        bundle.count = bundle.count + 2'd1;
      end else if (mid_mode == MODE_LT) begin
        bundle.toks[bundle.count] = '{KIND_ERR_LT, mid_start, LEN_ONE};
        bundle.count = bundle.count + 2'd1;
      end else if (mid_mode == MODE_MINUS) begin
        bundle.toks[bundle.count] = '{KIND_ERR_MINUS, mid_start, LEN_ONE};
        bundle.count = bundle.count + 2'd1;
      end
      bundle.toks[bundle.count] = '{KIND_EOL, pos_sat, LEN_ZERO};
      bundle.count = bundle.count + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= MODE_IDLE;
      start_pos <= '0;
      tok_len   <= LEN_ZERO;
      kw_match  <= 2'b11;
      byte_pos  <= '0;
    end else if (fire) begin
      scan_mode <= scan_mode_next;
      start_pos <= start_pos_next;
      tok_len   <= tok_len_next;
      kw_match  <= kw_match_next;
      byte_pos  <= byte_pos_next;
    end
  end

endmodule

/* sv/elt_queue.sv */
// Short bundle queue between the front and back parts.
`include "expression_line_tokenizer_core_assert.svh"

module elt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  elt_pkg::bundle_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output elt_pkg::bundle_t pop_data
);
  import elt_pkg::*;

  bundle_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push_fire;
  logic               pop_fire;

  assign push_ready = (count != QUEUE_FULL);
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) wr_ptr <= wr_ptr + 1'b1;
      if (pop_fire) rd_ptr <= rd_ptr + 1'b1;
      if (push_fire && !pop_fire) count <= count + 1'b1;
      else if (pop_fire && !push_fire) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) slots[wr_ptr] <= push_data;
  end

  `ELT_ASSERT(a_count_bound, count <= QUEUE_FULL, "queue count beyond depth")
  `ELT_ASSERT(a_no_empty_bundle, !push_valid || push_data.count != 2'd0, "empty bundle pushed")
  `ELT_ASSERT_NEXT(a_count_up, push_fire && !pop_fire, count == $past(count) + 1'b1, "count lost")

endmodule

/* sv/elt_back.sv */
// Back part: unpack each bundle into one descriptor item per cycle while the token port is ready.
`include "expression_line_tokenizer_core_assert.svh"

module elt_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  elt_pkg::bundle_t pop_data,
  elt_out_if.source        token_ch
);
  import elt_pkg::*;

  bundle_t     cur;
  logic        cur_valid;
  logic [1:0]  idx;
  logic        is_last;
  logic        out_fire;
  tok_t        tok;

  assign is_last   = (idx == cur.count - 2'd1);
  assign out_fire  = cur_valid && token_ch.ready;
  assign pop_ready = !cur_valid || (token_ch.ready && is_last);
  assign tok       = cur.toks[idx];

  assign token_ch.valid        = cur_valid;
  assign token_ch.token_kind   = tok.kind;
  assign token_ch.token_start  = tok.start;
  assign token_ch.token_length = tok.length;
  assign token_ch.run_end      = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (pop_ready) begin
      cur_valid <= pop_valid;
      idx       <= 2'd0;
    end else if (out_fire) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) cur <= pop_data;
  end

  `ELT_ASSERT(a_idx_in_range, !cur_valid || (idx < cur.count), "slot index past bundle")
  `ELT_ASSERT_NEXT(a_idx_step, out_fire && !is_last, cur_valid && idx == $past(idx) + 2'd1, "slot skipped")
  `ELT_ASSERT_NEXT(a_stall_hold, token_ch.valid && !token_ch.ready, token_ch.valid, "item dropped")

endmodule

/* sv/expression_line_tokenizer_core.sv */
// A byte's first descriptor is held in a queue slot, then in the back bundle register.
// Throughput: one byte per cycle while each byte yields at most one descriptor
// and the token port is ready; that port sends a byte's results one descriptor per cycle.
// The four-entry bundle queue absorbs bursts of multi-result bytes; when full, bytes stall.
// Reset (rst, synchronous, active high) empties the queue and returns the scanner to idle
// at line position zero.
module expression_line_tokenizer_core (
  input  logic clk,
  input  logic rst,
  elt_in_if.sink    byte_ch,
  elt_out_if.source token_ch
);
  import elt_pkg::*;

  // Front to queue.
  logic    push_valid;
  logic    push_ready;
  bundle_t push_data;

  // Queue to back.
  logic    pop_valid;
  logic    pop_ready;
  bundle_t pop_data;

  // Front: hold the scan state, classify each byte and build the bundle of
  // descriptors it causes (none up to three). Take a byte whenever the queue
  // has a free slot; bytes with no result update the state and push nothing.
  elt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_ch    (byte_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Queue: decouple the byte side from the token side so either can stall.
  elt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: hold one bundle in a register and advance through its slots, one
  // descriptor per accepted item; mark the last slot with run_end and pull
  // the next bundle in the same cycle the last slot goes out.
  elt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .token_ch  (token_ch)
  );

endmodule
